@@ design/agc_pkg.sv @@
package agc_pkg;

  // field and datapath widths
  localparam int unsigned SMP_W     = 16;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned ENV_W     = 17;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned MAC_W     = 18;
  localparam int unsigned ACC_W     = 2 * MAC_W;
  localparam int unsigned DIV_NUM_W = COEF_W + 11;
  localparam int unsigned DIV_DEN_W = ENV_W;
  localparam int unsigned DIV_CNT_W = 5;
  localparam int unsigned CFG_IDX_W = 3;

  // fixed-point constants
  localparam logic [ENV_W-1:0]  ONE_Q16    = 17'd65536;
  localparam logic [ENV_W-1:0]  ENV_MAX    = 17'd65536;
  localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd2048;
  localparam logic [GAIN_W-1:0] MIN_GAIN   = 16'd205;
  localparam logic [15:0]       RND_Q16    = 16'd32768;
  localparam logic [15:0]       RND_Q11    = 16'd1024;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEVEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEFF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEFF = 3'd4;

  // input item kinds
  localparam logic KIND_FRAME   = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  // multiply-accumulate control
  typedef struct packed {
    logic        load;
    logic        accum;
    logic [15:0] rnd;
  } mac_ctl_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ design/agc_cfg_if.sv @@
interface agc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [agc_pkg::CFG_IDX_W-1:0]  index;
  logic [agc_pkg::COEF_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/agc_in_if.sv @@
interface agc_in_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic signed [agc_pkg::SMP_W-1:0] left_in;
  logic signed [agc_pkg::SMP_W-1:0] right_in;

  modport source (output valid, output kind, output left_in, output right_in, input ready);
  modport sink (input valid, input kind, input left_in, input right_in, output ready);
endinterface

@@ design/agc_out_if.sv @@
interface agc_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [agc_pkg::SMP_W-1:0] left_out;
  logic signed [agc_pkg::SMP_W-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink (input valid, input left_out, input right_out, output ready);
endinterface

@@ design/stereo_auto_gain_control.sv @@
// an enabled frame passes the envelope, divide (skipped when the new envelope is zero),
// gain, sample and store steps; a disabled frame goes straight to store; a restart is done in idle
// throughput: one item at a time, next taken the cycle after the result is stored if no
// register write waits; the restoring divider and the shared multiplier set the pace
// reset: synchronous, registers take their reset values, envelope 32768, gain unity
module stereo_auto_gain_control (
  input  logic       clk,
  input  logic       rst,
  agc_cfg_if.sink    cfg,
  agc_in_if.sink     in_ch,
  agc_out_if.source  out_ch
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ENV_A  = 4'd1;
  localparam logic [3:0] S_ENV_B  = 4'd2;
  localparam logic [3:0] S_ENV_C  = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_GAIN_A = 4'd5;
  localparam logic [3:0] S_GAIN_B = 4'd6;
  localparam logic [3:0] S_GAIN_C = 4'd7;
  localparam logic [3:0] S_LEFT   = 4'd8;
  localparam logic [3:0] S_RIGHT  = 4'd9;
  localparam logic [3:0] S_SAT    = 4'd10;
  localparam logic [3:0] S_PUSH   = 4'd11;

  logic [3:0] state;

  // configuration registers
  logic                          enabled;
  logic [agc_pkg::COEF_W-1:0]    target_level;
  logic [agc_pkg::GAIN_W-1:0]    max_gain;
  logic [agc_pkg::COEF_W-1:0]    attack_coeff;
  logic [agc_pkg::COEF_W-1:0]    release_coeff;

  // tracking state
  logic [agc_pkg::ENV_W-1:0]     env;
  logic [agc_pkg::GAIN_W-1:0]    gain;

  // per-item working registers
  logic signed [agc_pkg::SMP_W-1:0] smp_l;
  logic signed [agc_pkg::SMP_W-1:0] smp_r;
  logic [agc_pkg::ENV_W-1:0]        peak;
  logic [agc_pkg::COEF_W-1:0]       coef;
  logic [agc_pkg::GAIN_W-1:0]       tgt;
  logic signed [agc_pkg::SMP_W-1:0] res_l;
  logic signed [agc_pkg::SMP_W-1:0] res_r;

  // output register
  logic                             out_valid;
  logic signed [agc_pkg::SMP_W-1:0] out_l;
  logic signed [agc_pkg::SMP_W-1:0] out_r;

  // shared units
  agc_pkg::mac_ctl_t                   mac_ctl;
  logic signed [agc_pkg::MAC_W-1:0]    mac_a;
  logic signed [agc_pkg::MAC_W-1:0]    mac_b;
  logic signed [agc_pkg::ACC_W-1:0]    acc;
  agc_pkg::div_stat_t                  div_stat;
  logic                                div_start;
  logic [agc_pkg::DIV_NUM_W-1:0]       div_quo;

  logic [agc_pkg::SMP_W-1:0]  mag_l;
  logic [agc_pkg::SMP_W-1:0]  mag_r;
  logic [agc_pkg::ENV_W-1:0]  peak_in;
  logic [agc_pkg::ENV_W-1:0]  env_new;
  logic [agc_pkg::COEF_W-1:0] coef_sel;
  logic [agc_pkg::ENV_W-1:0]  one_minus;
  logic [agc_pkg::DIV_NUM_W-1:0] quo_lo;
  logic [agc_pkg::GAIN_W-1:0] tgt_clamped;

  // round-shifted product to q15 sample with saturation
  function automatic logic signed [agc_pkg::SMP_W-1:0] sat_q11(
    input logic signed [agc_pkg::ACC_W-1:0] v
  );
    logic signed [agc_pkg::ACC_W-1:0] s;
    s = v >>> 11;
    if (s > 36'sd32767) begin
      return 16'sh7fff;
    end else if (s < -36'sd32768) begin
      return 16'sh8000;
    end else begin
      return s[agc_pkg::SMP_W-1:0];
    end
  endfunction

  // peak of the incoming frame
  assign mag_l   = in_ch.left_in[15] ? 16'(-in_ch.left_in) : 16'(in_ch.left_in);
  assign mag_r   = in_ch.right_in[15] ? 16'(-in_ch.right_in) : 16'(in_ch.right_in);
  assign peak_in = (mag_r > mag_l) ? {mag_r, 1'b0} : {mag_l, 1'b0};

  // smoothing weight complement
  assign coef_sel  = (state == S_ENV_B) ? coef : release_coeff;
  assign one_minus = agc_pkg::ONE_Q16 - {1'b0, coef_sel};

  // new envelope from accumulator
  assign env_new = acc[32:16];

  // target gain clamp: lower bound first, then max_gain
  assign quo_lo      = (div_quo < agc_pkg::DIV_NUM_W'(agc_pkg::MIN_GAIN)) ?
                       agc_pkg::DIV_NUM_W'(agc_pkg::MIN_GAIN) : div_quo;
  assign tgt_clamped = (quo_lo > agc_pkg::DIV_NUM_W'(max_gain)) ?
                       max_gain : quo_lo[agc_pkg::GAIN_W-1:0];

  assign div_start = (state == S_ENV_C) && (env_new != '0);

  // operand select for the shared multiplier
  always_comb begin
    mac_ctl = '0;
    mac_a   = '0;
    mac_b   = '0;
    unique case (state)
      S_ENV_A: begin
        mac_a       = $signed({1'b0, env});
        mac_b       = $signed({2'b0, coef});
        mac_ctl.load = 1'b1;
        mac_ctl.rnd  = agc_pkg::RND_Q16;
      end
      S_ENV_B: begin
        mac_a         = $signed({1'b0, one_minus});
        mac_b         = $signed({1'b0, peak});
        mac_ctl.accum = 1'b1;
      end
      S_GAIN_A: begin
        mac_a       = $signed({2'b0, release_coeff});
        mac_b       = $signed({2'b0, gain});
        mac_ctl.load = 1'b1;
        mac_ctl.rnd  = agc_pkg::RND_Q16;
      end
      S_GAIN_B: begin
        mac_a         = $signed({1'b0, one_minus});
        mac_b         = $signed({2'b0, tgt});
        mac_ctl.accum = 1'b1;
      end
      S_LEFT: begin
        mac_a       = {{2{smp_l[15]}}, smp_l};
        mac_b       = $signed({2'b0, gain});
        mac_ctl.load = 1'b1;
        mac_ctl.rnd  = agc_pkg::RND_Q11;
      end
      S_RIGHT: begin
        mac_a       = {{2{smp_r[15]}}, smp_r};
        mac_b       = $signed({2'b0, gain});
        mac_ctl.load = 1'b1;
        mac_ctl.rnd  = agc_pkg::RND_Q11;
      end
      default: begin
        mac_ctl = '0;
      end
    endcase
  end

  agc_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  agc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({target_level, 11'b0}),
    .den   (env_new),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  // sequencer, tracking state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      enabled       <= 1'b0;
      target_level  <= 16'd32768;
      max_gain      <= 16'd8192;
      attack_coeff  <= 16'd65524;
      release_coeff <= 16'd65533;
      env           <= 17'd32768;
      gain          <= agc_pkg::UNITY_GAIN;
    end else begin
      // result register: set by the store step, cleared when the beat is taken
      if ((state == S_PUSH) && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            smp_l <= in_ch.left_in;
            smp_r <= in_ch.right_in;
            peak  <= peak_in;
            coef  <= (peak_in > env) ? attack_coeff : release_coeff;
            res_l <= in_ch.left_in;
            res_r <= in_ch.right_in;
            if (in_ch.kind == agc_pkg::KIND_RESTART) begin
              env  <= {1'b0, target_level};
              gain <= agc_pkg::UNITY_GAIN;
            end else if (!enabled) begin
              state <= S_PUSH;
            end else begin
              state <= S_ENV_A;
            end
          end
        end
        S_ENV_A: state <= S_ENV_B;
        S_ENV_B: state <= S_ENV_C;
        S_ENV_C: begin
          env <= env_new;
          if (env_new == '0) begin
            tgt   <= agc_pkg::UNITY_GAIN;
            state <= S_GAIN_A;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            tgt   <= tgt_clamped;
            state <= S_GAIN_A;
          end
        end
        S_GAIN_A: state <= S_GAIN_B;
        S_GAIN_B: state <= S_GAIN_C;
        S_GAIN_C: begin
          gain  <= acc[31:16];
          state <= S_LEFT;
        end
        S_LEFT: state <= S_RIGHT;
        S_RIGHT: begin
          res_l <= sat_q11(acc);
          state <= S_SAT;
        end
        S_SAT: begin
          res_r <= sat_q11(acc);
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (!out_valid || out_ch.ready) begin
            out_l     <= res_l;
            out_r     <= res_r;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // register writes, only while idle
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          agc_pkg::REG_ENABLED: begin
            if (cfg.data[0] && !enabled) begin
              env  <= {1'b0, target_level};
              gain <= agc_pkg::UNITY_GAIN;
            end
            enabled <= cfg.data[0];
          end
          agc_pkg::REG_TARGET_LEVEL:  target_level  <= cfg.data;
          agc_pkg::REG_MAX_GAIN:      max_gain      <= cfg.data;
          agc_pkg::REG_ATTACK_COEFF:  attack_coeff  <= cfg.data;
          agc_pkg::REG_RELEASE_COEFF: release_coeff <= cfg.data;
          default: ;
        endcase
      end
    end
  end

  // a register write takes precedence over an input beat while idle
  assign cfg.ready       = (state == S_IDLE);
  assign in_ch.ready     = (state == S_IDLE) && !cfg.valid;
  assign out_ch.valid    = out_valid;
  assign out_ch.left_out = out_l;
  assign out_ch.right_out = out_r;

  // a result appears only from the store step
  a_push_only: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_PUSH)
    else $error("result beat raised outside store step");

  // divider finishes only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == S_DIV)
    else $error("divider done outside divide step");

  // envelope stays within full scale
  a_env_range: assert property (@(posedge clk) disable iff (rst)
    env <= agc_pkg::ENV_MAX)
    else $error("envelope above full scale");

  // restart beat reloads envelope and gain
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && in_ch.kind == agc_pkg::KIND_RESTART)
      |=> (env == {1'b0, $past(target_level)}) && (gain == agc_pkg::UNITY_GAIN))
    else $error("restart did not reload state");

endmodule

@@ design/agc_mac.sv @@
module agc_mac (
  input  logic                                clk,
  input  agc_pkg::mac_ctl_t                   ctl,
  input  logic signed [agc_pkg::MAC_W-1:0]    a,
  input  logic signed [agc_pkg::MAC_W-1:0]    b,
  output logic signed [agc_pkg::ACC_W-1:0]    acc
);

  logic signed [agc_pkg::ACC_W-1:0] prod;
  logic signed [agc_pkg::ACC_W-1:0] rnd_ext;

  // single signed multiplier
  assign prod    = a * b;
  assign rnd_ext = $signed({{(agc_pkg::ACC_W-16){1'b0}}, ctl.rnd});

  // accumulator: load product plus rounding constant or add product to running sum
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc <= prod + rnd_ext;
    end else if (ctl.accum) begin
      acc <= acc + prod;
    end
  end

endmodule

@@ design/agc_div.sv @@
module agc_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [agc_pkg::DIV_NUM_W-1:0]     num,
  input  logic [agc_pkg::DIV_DEN_W-1:0]     den,
  output agc_pkg::div_stat_t                stat,
  output logic [agc_pkg::DIV_NUM_W-1:0]     quo
);

  logic                              busy;
  logic                              done;
  logic [agc_pkg::DIV_CNT_W-1:0]     cnt;
  logic [agc_pkg::DIV_DEN_W-1:0]     rem;
  logic [agc_pkg::DIV_DEN_W-1:0]     dsr;
  logic [agc_pkg::DIV_DEN_W:0]       rem_sh;
  logic [agc_pkg::DIV_DEN_W:0]       diff;
  logic                              ge;

  // one restoring step: shift in next dividend bit, trial subtract
  assign rem_sh = {rem, quo[agc_pkg::DIV_NUM_W-1]};
  assign diff   = rem_sh - {1'b0, dsr};
  assign ge     = (rem_sh >= {1'b0, dsr});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == agc_pkg::DIV_CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= agc_pkg::DIV_CNT_W'(agc_pkg::DIV_NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == agc_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // dividend shifts out while quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dsr <= den;
    end else if (busy) begin
      quo <= {quo[agc_pkg::DIV_NUM_W-2:0], ge};
      rem <= ge ? diff[agc_pkg::DIV_DEN_W-1:0] : rem_sh[agc_pkg::DIV_DEN_W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule
